// ===== hw/rtl/cas_pkg.sv =====
// shared types and codes for the cursor array sequence block
package cas_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT         = 3'd0,
    CMD_INSERT_FRONT   = 3'd1,
    CMD_ATTACH         = 3'd2,
    CMD_ATTACH_BACK    = 3'd3,
    CMD_REMOVE_CURRENT = 3'd4,
    CMD_REMOVE_FRONT   = 3'd5,
    CMD_READ_AT        = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_NO_CURRENT = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_BAD_INDEX  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] entry_value;
    logic [4:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [5:0]  count;
    logic [5:0]  cursor;
    logic        has_current;
    logic [2:0]  status;
  } rsp_t;

endpackage

// ===== hw/rtl/cas_cell.sv =====
// one storage cell of the entry row, shifts with its neighbors
module cas_cell #(
  parameter int CNT_BITS   = 6,
  parameter int VALUE_BITS = 32,
  parameter int IDX        = 0
) (
  input  logic                  clk_i,
  input  cas_pkg::cell_op_e     op_i,
  input  logic [CNT_BITS-1:0]   pos_i,
  input  logic [CNT_BITS-1:0]   cnt_i,
  input  logic [VALUE_BITS-1:0] new_value_i,
  input  logic [VALUE_BITS-1:0] left_i,
  input  logic [VALUE_BITS-1:0] right_i,
  input  logic [4:0]            rd_idx_i,
  output logic [VALUE_BITS-1:0] value_o,
  output logic [VALUE_BITS-1:0] rd_o
);

  localparam logic [CNT_BITS-1:0] MyIdx   = CNT_BITS'(IDX);
  localparam logic [CNT_BITS-1:0] NextIdx = CNT_BITS'(IDX + 1);
  localparam logic                Readable = (IDX < 32);
  localparam logic [4:0]          RdIdx   = 5'(IDX);

  logic [VALUE_BITS-1:0] value_d, value_q;

  always_comb begin
    value_d = value_q;
    case (op_i)
      cas_pkg::OP_OPEN: begin
        if (MyIdx == pos_i) begin
          value_d = new_value_i;
        end else if (MyIdx > pos_i && MyIdx <= cnt_i) begin
          value_d = left_i;
        end
      end
      cas_pkg::OP_CLOSE: begin
        if (MyIdx >= pos_i && NextIdx < cnt_i) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // and-or read bus: only the addressed cell drives nonzero
  assign rd_o = (Readable && rd_idx_i == RdIdx) ? value_q : '0;

endmodule

// ===== hw/rtl/cas_ctrl.sv =====
// command decode, count and cursor registers, cell row control
module cas_ctrl #(
  parameter int CAPACITY_ENTRIES = 32,
  parameter int CNT_BITS         = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [2:0]            command_i,
  input  logic [4:0]            read_index_i,
  output cas_pkg::cell_op_e     op_o,
  output logic [CNT_BITS-1:0]   pos_o,
  output logic [CNT_BITS-1:0]   cnt_q_o,
  output logic [CNT_BITS-1:0]   cnt_d_o,
  output logic [CNT_BITS-1:0]   cur_d_o,
  output cas_pkg::status_e      status_o,
  output logic                  read_ok_o
);

  localparam logic [CNT_BITS-1:0] CapCount = CNT_BITS'(CAPACITY_ENTRIES);
  localparam logic [CNT_BITS-1:0] One      = CNT_BITS'(1);
  localparam int IdxBits = (CNT_BITS > 5) ? CNT_BITS : 5;

  logic [CNT_BITS-1:0] cnt_q, cnt_d, cur_q, cur_d;
  logic                has_cur, full;
  logic [IdxBits-1:0]  idx_x, cnt_x;
  cas_pkg::cmd_e       cmd;
  cas_pkg::cell_op_e   op;

  assign cmd     = cas_pkg::cmd_e'(command_i);
  assign has_cur = cur_q < cnt_q;
  assign full    = cnt_q == CapCount;
  assign idx_x   = IdxBits'(read_index_i);
  assign cnt_x   = IdxBits'(cnt_q);

  always_comb begin
    op        = cas_pkg::OP_HOLD;
    pos_o     = '0;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    status_o  = cas_pkg::ST_OK;
    read_ok_o = 1'b0;
    unique case (cmd)
      cas_pkg::CMD_INSERT: begin
        if (full) begin
          status_o = cas_pkg::ST_FULL;
        end else begin
          op    = cas_pkg::OP_OPEN;
          pos_o = has_cur ? cur_q : '0;
          cur_d = has_cur ? cur_q : '0;
          cnt_d = cnt_q + One;
        end
      end
      cas_pkg::CMD_INSERT_FRONT: begin
        if (full) begin
          status_o = cas_pkg::ST_FULL;
        end else begin
          op    = cas_pkg::OP_OPEN;
          pos_o = '0;
          cur_d = '0;
          cnt_d = cnt_q + One;
        end
      end
      cas_pkg::CMD_ATTACH: begin
        if (full) begin
          status_o = cas_pkg::ST_FULL;
        end else begin
          op    = cas_pkg::OP_OPEN;
          pos_o = has_cur ? cur_q + One : cnt_q;
          cur_d = has_cur ? cur_q + One : cnt_q;
          cnt_d = cnt_q + One;
        end
      end
      cas_pkg::CMD_ATTACH_BACK: begin
        if (full) begin
          status_o = cas_pkg::ST_FULL;
        end else begin
          op    = cas_pkg::OP_OPEN;
          pos_o = cnt_q;
          cur_d = cnt_q;
          cnt_d = cnt_q + One;
        end
      end
      cas_pkg::CMD_REMOVE_CURRENT: begin
        if (!has_cur) begin
          status_o = cas_pkg::ST_NO_CURRENT;
        end else begin
          op    = cas_pkg::OP_CLOSE;
          pos_o = cur_q;
          cnt_d = cnt_q - One;
        end
      end
      cas_pkg::CMD_REMOVE_FRONT: begin
        if (cnt_q == '0) begin
          status_o = cas_pkg::ST_EMPTY;
        end else begin
          op    = cas_pkg::OP_CLOSE;
          pos_o = '0;
          cnt_d = cnt_q - One;
        end
      end
      cas_pkg::CMD_READ_AT: begin
        if (idx_x >= cnt_x) begin
          status_o = cas_pkg::ST_BAD_INDEX;
        end else begin
          read_ok_o = 1'b1;
        end
      end
      default: begin
        op = cas_pkg::OP_HOLD;
      end
    endcase
  end

  // cells only move on an accepted transaction
  assign op_o    = accept_i ? op : cas_pkg::OP_HOLD;
  assign cnt_q_o = cnt_q;
  assign cnt_d_o = cnt_d;
  assign cur_d_o = cur_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cur_q <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
      cur_q <= cur_d;
    end
  end

endmodule

// ===== hw/rtl/cursor_array_sequence.sv =====
// top level: ordered entry row with a cursor, one command per cycle
// A command is taken at every clock edge with start high (busy stays low, so a new command may
// follow in each cycle). Its result appears on rsp_o with result_valid_o high for exactly one
// cycle, the cycle right after the command was taken; it must be captured then. The rate is
// one command per cycle: every cell of the row decides its own move from
// the cursor, the count and its index and shifts with its neighbor in the same edge, and a read
// selects one cell through an and-or bus that is registered into the result. Entries are not
// cleared at reset; only held entries can be read.
module cursor_array_sequence #(
  parameter int CAPACITY_ENTRIES = 32,
  parameter int VALUE_BITS       = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cas_pkg::req_t req_i,
  output logic          result_valid_o,
  output cas_pkg::rsp_t rsp_o
);

  localparam int CntBits = $clog2(CAPACITY_ENTRIES + 1);
  localparam int ExtBits = (CntBits > 6) ? CntBits : 6;

  logic                  accept;
  cas_pkg::cell_op_e     op;
  logic [CntBits-1:0]    pos, cnt_q, cnt_d, cur_d;
  cas_pkg::status_e      status;
  logic                  read_ok;
  logic [63:0]           value_ext, rd_ext;
  logic [VALUE_BITS-1:0] new_value, rd_all;
  logic [VALUE_BITS-1:0] cell_value [CAPACITY_ENTRIES];
  logic [VALUE_BITS-1:0] cell_rd    [CAPACITY_ENTRIES];
  logic [ExtBits-1:0]    cnt_ext, cur_ext;
  logic                  result_valid_q;
  cas_pkg::rsp_t         rsp_d, rsp_q;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign value_ext = {32'b0, req_i.entry_value};
  assign new_value = value_ext[VALUE_BITS-1:0];

  cas_ctrl #(
    .CAPACITY_ENTRIES(CAPACITY_ENTRIES),
    .CNT_BITS        (CntBits)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (req_i.command),
    .read_index_i(req_i.read_index),
    .op_o        (op),
    .pos_o       (pos),
    .cnt_q_o     (cnt_q),
    .cnt_d_o     (cnt_d),
    .cur_d_o     (cur_d),
    .status_o    (status),
    .read_ok_o   (read_ok)
  );

  for (genvar i = 0; i < CAPACITY_ENTRIES; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_value[i-1];
    end
    if (i == CAPACITY_ENTRIES - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_value[i+1];
    end

    cas_cell #(
      .CNT_BITS  (CntBits),
      .VALUE_BITS(VALUE_BITS),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .pos_i      (pos),
      .cnt_i      (cnt_q),
      .new_value_i(new_value),
      .left_i     (left),
      .right_i    (right),
      .rd_idx_i   (req_i.read_index),
      .value_o    (cell_value[i]),
      .rd_o       (cell_rd[i])
    );
  end

  always_comb begin
    rd_all = '0;
    for (int i = 0; i < CAPACITY_ENTRIES; i++) begin
      rd_all = rd_all | cell_rd[i];
    end
  end

  assign rd_ext  = 64'(rd_all);
  assign cnt_ext = ExtBits'(cnt_d);
  assign cur_ext = ExtBits'(cur_d);

  always_comb begin
    rsp_d.read_value  = read_ok ? rd_ext[31:0] : 32'b0;
    rsp_d.count       = cnt_ext[5:0];
    rsp_d.cursor      = cur_ext[5:0];
    rsp_d.has_current = cur_d < cnt_d;
    rsp_d.status      = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign rsp_o          = rsp_q;

endmodule

// ===== hw/rtl/cas_checker.sv =====
// port level checks for the cursor array sequence, bound to the top level
module cas_checker #(
  parameter int CAPACITY_ENTRIES = 32
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input cas_pkg::req_t req_i,
  input logic          result_valid_o,
  input cas_pkg::rsp_t rsp_o
);

  localparam logic NarrowCount = (CAPACITY_ENTRIES < 64);

  // every result strobe answers a transaction taken in the cycle before
  a_result_follows_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy))
    else $error("result strobe without a preceding transaction");

  a_cmd_gets_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_valid_o)
    else $error("transaction without a result");

  a_has_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && NarrowCount) |-> (rsp_o.has_current == (rsp_o.cursor < rsp_o.count)))
    else $error("has_current disagrees with cursor and count");

  // only a successful read carries data
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && ($past(req_i.command) != cas_pkg::CMD_READ_AT
      || rsp_o.status != cas_pkg::ST_OK)) |-> (rsp_o.read_value == 32'b0))
    else $error("read value nonzero outside a successful read");

endmodule

bind cursor_array_sequence cas_checker #(
  .CAPACITY_ENTRIES(CAPACITY_ENTRIES)
) u_cas_checker (.*);
